// ----- hdl/nssl_pkg.sv -----
// Shared types, constants and fixed-point helpers of the nine-slice sprite layout block.
package nssl_pkg;

    localparam int SRC_COORD_BITS = 12;
    localparam int DST_FRAC_BITS  = 4;
    localparam int DST_W          = 16;
    localparam int SCALE_W        = 12;
    localparam int SCALE_FRAC     = 8;
    localparam int SCALE_SHIFT    = SCALE_FRAC - DST_FRAC_BITS;
    localparam int PROD_W         = SRC_COORD_BITS + 1 + SCALE_W + 1;
    localparam int DST_LIM        = 2 ** (DST_W - 1);
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(2 ** SCALE_FRAC);
    localparam logic [SRC_COORD_BITS-1:0] SRC_MAX = {SRC_COORD_BITS{1'b1}};
    localparam logic signed [DST_W-1:0] DST_MAX = {1'b0, {(DST_W-1){1'b1}}};
    localparam logic signed [DST_W-1:0] DST_MIN = {1'b1, {(DST_W-1){1'b0}}};

    // Register index, taken from the word address of the APB port
    localparam logic REG_SCALE_FACTOR = 1'b0;

    typedef logic [SRC_COORD_BITS-1:0]  t_src;
    typedef logic signed [DST_W-1:0]    t_dst;
    typedef logic [SCALE_W-1:0]         t_scale;

    typedef enum logic [1:0] {
        OP_LOAD_OUTER = 2'd0,
        OP_LOAD_CORE  = 2'd1,
        OP_LOAD_PIVOT = 2'd2,
        OP_DRAW       = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        SL_CENTRE = 4'd0,
        SL_TL     = 4'd1,
        SL_TR     = 4'd2,
        SL_BL     = 4'd3,
        SL_BR     = 4'd4,
        SL_TOP    = 4'd5,
        SL_BOTTOM = 4'd6,
        SL_LEFT   = 4'd7,
        SL_RIGHT  = 4'd8
    } t_slice;

    typedef struct packed {
        t_op  operation;
        t_dst coord_a;
        t_dst coord_b;
        t_dst coord_c;
        t_dst coord_d;
        logic nine_slice;
    } t_in_item;

    typedef struct packed {
        logic [3:0] slice_index;
        t_src       src_left;
        t_src       src_top;
        t_src       src_right;
        t_src       src_bottom;
        t_dst       dst_left;
        t_dst       dst_top;
        t_dst       dst_right;
        t_dst       dst_bottom;
        logic       last_slice;
    } t_out_item;

    // Finished layout of one draw: outer and core source edges, outer and core
    // destination edges
    typedef struct packed {
        logic has_core;
        t_src ox0;
        t_src oy0;
        t_src ox1;
        t_src oy1;
        t_src cx0;
        t_src cy0;
        t_src cx1;
        t_src cy1;
        t_dst dl;
        t_dst dt;
        t_dst dr;
        t_dst db;
        t_dst cl;
        t_dst ct;
        t_dst cr;
        t_dst cb;
    } t_layout;

    function automatic t_dst sat_dst(input logic signed [DST_W:0] v);
        t_dst r;
        if (v[DST_W] != v[DST_W-1]) begin
            r = v[DST_W] ? DST_MIN : DST_MAX;
        end else begin
            r = v[DST_W-1:0];
        end
        return r;
    endfunction

    function automatic t_src sat_src(input logic [SRC_COORD_BITS:0] v);
        t_src r;
        r = v[SRC_COORD_BITS] ? SRC_MAX : v[SRC_COORD_BITS-1:0];
        return r;
    endfunction

    // Pixel value times scale, truncated toward zero into Q12.4, saturated
    function automatic t_dst scale_px(input logic signed [SRC_COORD_BITS:0] p,
                                      input t_scale s);
        logic signed [PROD_W-1:0] prod;
        logic [PROD_W-1:0]        mag;
        logic [PROD_W-1:0]        q;
        logic                     neg;
        t_dst                     r;
        prod = PROD_W'(p) * $signed({1'b0, s});
        neg  = prod[PROD_W-1];
        mag  = neg ? PROD_W'(-prod) : PROD_W'(prod);
        q    = mag >> SCALE_SHIFT;
        if (neg) begin
            r = (q > PROD_W'(DST_LIM)) ? DST_MIN : DST_W'(-q);
        end else begin
            r = (q > PROD_W'(DST_LIM - 1)) ? DST_MAX : DST_W'(q);
        end
        return r;
    endfunction

    function automatic logic signed [SRC_COORD_BITS:0] src_diff(input t_src a, input t_src b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

// ----- hdl/nssl_slicer.sv -----
// Result sequencer: holds one draw's layout, emits its rectangle pairs one per cycle while the output is ready.
module nssl_slicer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nssl_pkg::t_layout  i_lay,
    input  logic               i_lay_valid,
    output logic               o_lay_ready,
    output nssl_pkg::t_out_item o_out,
    output logic               o_out_valid,
    input  logic               i_out_ready
);
    import nssl_pkg::*;

    t_layout r_lay;
    logic    r_v;
    t_slice  r_idx;
    logic    last;
    logic    take;

    assign last        = !r_lay.has_core || (r_idx == SL_RIGHT);
    assign take        = !r_v || (i_out_ready && last);
    assign o_lay_ready = take;
    assign o_out_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_idx <= SL_CENTRE;
        end else if (take) begin
            r_v   <= i_lay_valid;
            r_idx <= SL_CENTRE;
        end else if (i_out_ready) begin
            r_idx <= t_slice'(r_idx + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_lay_valid) begin
            r_lay <= i_lay;
        end
    end

    always_comb begin
        o_out             = '0;
        o_out.slice_index = r_idx;
        o_out.last_slice  = last;
        if (!r_lay.has_core) begin
            o_out.src_left   = r_lay.ox0;
            o_out.src_top    = r_lay.oy0;
            o_out.src_right  = r_lay.ox1;
            o_out.src_bottom = r_lay.oy1;
            o_out.dst_left   = r_lay.dl;
            o_out.dst_top    = r_lay.dt;
            o_out.dst_right  = r_lay.dr;
            o_out.dst_bottom = r_lay.db;
        end else begin
            unique case (r_idx)
                SL_CENTRE: begin
                    o_out.src_left = r_lay.cx0; o_out.src_top = r_lay.cy0;
                    o_out.src_right = r_lay.cx1; o_out.src_bottom = r_lay.cy1;
                    o_out.dst_left = r_lay.cl; o_out.dst_top = r_lay.ct;
                    o_out.dst_right = r_lay.cr; o_out.dst_bottom = r_lay.cb;
                end
                SL_TL: begin
                    o_out.src_left = r_lay.ox0; o_out.src_top = r_lay.oy0;
                    o_out.src_right = r_lay.cx0; o_out.src_bottom = r_lay.cy0;
                    o_out.dst_left = r_lay.dl; o_out.dst_top = r_lay.dt;
                    o_out.dst_right = r_lay.cl; o_out.dst_bottom = r_lay.ct;
                end
                SL_TR: begin
                    o_out.src_left = r_lay.cx1; o_out.src_top = r_lay.oy0;
                    o_out.src_right = r_lay.ox1; o_out.src_bottom = r_lay.cy0;
                    o_out.dst_left = r_lay.cr; o_out.dst_top = r_lay.dt;
                    o_out.dst_right = r_lay.dr; o_out.dst_bottom = r_lay.ct;
                end
                SL_BL: begin
                    o_out.src_left = r_lay.ox0; o_out.src_top = r_lay.cy1;
                    o_out.src_right = r_lay.cx0; o_out.src_bottom = r_lay.oy1;
                    o_out.dst_left = r_lay.dl; o_out.dst_top = r_lay.cb;
                    o_out.dst_right = r_lay.cl; o_out.dst_bottom = r_lay.db;
                end
                SL_BR: begin
                    o_out.src_left = r_lay.cx1; o_out.src_top = r_lay.cy1;
                    o_out.src_right = r_lay.ox1; o_out.src_bottom = r_lay.oy1;
                    o_out.dst_left = r_lay.cr; o_out.dst_top = r_lay.cb;
                    o_out.dst_right = r_lay.dr; o_out.dst_bottom = r_lay.db;
                end
                SL_TOP: begin
                    o_out.src_left = r_lay.cx0; o_out.src_top = r_lay.oy0;
                    o_out.src_right = r_lay.cx1; o_out.src_bottom = r_lay.cy0;
                    o_out.dst_left = r_lay.cl; o_out.dst_top = r_lay.dt;
                    o_out.dst_right = r_lay.cr; o_out.dst_bottom = r_lay.ct;
                end
                SL_BOTTOM: begin
                    o_out.src_left = r_lay.cx0; o_out.src_top = r_lay.cy1;
                    o_out.src_right = r_lay.cx1; o_out.src_bottom = r_lay.oy1;
                    o_out.dst_left = r_lay.cl; o_out.dst_top = r_lay.cb;
                    o_out.dst_right = r_lay.cr; o_out.dst_bottom = r_lay.db;
                end
                SL_LEFT: begin
                    o_out.src_left = r_lay.ox0; o_out.src_top = r_lay.cy0;
                    o_out.src_right = r_lay.cx0; o_out.src_bottom = r_lay.cy1;
                    o_out.dst_left = r_lay.dl; o_out.dst_top = r_lay.ct;
                    o_out.dst_right = r_lay.cl; o_out.dst_bottom = r_lay.cb;
                end
                SL_RIGHT: begin
                    o_out.src_left = r_lay.cx1; o_out.src_top = r_lay.cy0;
                    o_out.src_right = r_lay.ox1; o_out.src_bottom = r_lay.cy1;
                    o_out.dst_left = r_lay.cr; o_out.dst_top = r_lay.ct;
                    o_out.dst_right = r_lay.dr; o_out.dst_bottom = r_lay.cb;
                end
                default: begin
                    o_out.src_left = r_lay.cx0; o_out.src_top = r_lay.cy0;
                    o_out.src_right = r_lay.cx1; o_out.src_bottom = r_lay.cy1;
                    o_out.dst_left = r_lay.cl; o_out.dst_top = r_lay.ct;
                    o_out.dst_right = r_lay.cr; o_out.dst_bottom = r_lay.cb;
                end
            endcase
        end
    end

endmodule

// ----- hdl/nine_slice_sprite_layout.sv -----
// Top level of the nine-slice sprite layout block: frame store, layout pipeline, APB register.
//
// Load requests (outer bounds, core, pivot and nine-slice flag) update the frame store at
// acceptance and produce no result. A draw request passes four register stages (frame
// snapshot, eight parallel scale multipliers, pivot shift, edge widening and core edges) and
// then enters the result sequencer's layout register, from which its first rectangle pair is
// emitted. The sequencer emits one pair per cycle while the result port is ready: a plain
// draw yields one pair, a nine-slice draw nine (centre, TL, TR, BL, BR, top, bottom, left,
// right), and the sustained rate is set by that one-pair-per-cycle result port. Requests are
// taken every cycle while the pipeline has room, also while a result waits. scale_factor sits
// at APB byte address 0 (unsigned Q4.8, reset 256); a value of zero acts as one.
module nine_slice_sprite_layout (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nssl_pkg::t_in_item             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nssl_pkg::t_out_item            o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nssl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [nssl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [nssl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import nssl_pkg::*;

    typedef struct packed {
        t_dst   x;
        t_dst   y;
        t_dst   w;
        t_dst   h;
        logic   has_core;
        t_src   ox0, oy0, ox1, oy1;
        t_src   cx0, cy0, cx1, cy1;
        t_src   px, py;
        t_scale s;
    } t_stage0;

    typedef struct packed {
        t_dst x, y, w, h;
        logic has_core;
        t_src ox0, oy0, ox1, oy1;
        t_src cx0, cy0, cx1, cy1;
        t_dst spx, spy, ow, oh, sdx0, sdy0, sdx1, sdy1;
    } t_stage1;

    typedef struct packed {
        t_dst l, t, w, h;
        logic has_core;
        t_src ox0, oy0, ox1, oy1;
        t_src cx0, cy0, cx1, cy1;
        t_dst ow, oh, sdx0, sdy0, sdx1, sdy1;
    } t_stage2;

    typedef struct packed {
        t_dst l, t, r, b;
        logic has_core;
        t_src ox0, oy0, ox1, oy1;
        t_src cx0, cy0, cx1, cy1;
        t_dst cl, ct, sdx1, sdy1;
    } t_stage3;

    // Frame store and register
    t_src   r_outer [4];
    t_src   r_core  [4];
    t_src   r_pivot [2];
    logic   r_has_core;
    t_scale r_scale;

    t_stage0 r_s0, n_s0;
    t_stage1 r_s1, n_s1;
    t_stage2 r_s2, n_s2;
    t_stage3 r_s3;
    t_stage3 n_s3;
    logic    r_s0_v, r_s1_v, r_s2_v, r_s3_v;
    logic    s0_ready, s1_ready, s2_ready, s3_ready;
    logic    in_acc, is_draw, cfg_wr;
    t_layout lay;
    logic    lay_ready;
    logic signed [DST_W:0] r0_diff, b0_diff;
    t_dst    r0, b0;

    assign in_acc  = i_in_valid && o_in_ready;
    assign is_draw = (i_in.operation == OP_DRAW);

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_SCALE_FACTOR) ? CFG_DATA_W'(r_scale) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_ONE;
        end else if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_SCALE_FACTOR) begin
            r_scale <= pwdata[SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer    <= '{default: '0};
            r_core     <= '{default: '0};
            r_pivot    <= '{default: '0};
            r_has_core <= 1'b0;
        end else if (in_acc) begin
            unique case (i_in.operation)
                OP_LOAD_OUTER: begin
                    r_outer[0] <= i_in.coord_a[SRC_COORD_BITS-1:0];
                    r_outer[1] <= i_in.coord_b[SRC_COORD_BITS-1:0];
                    r_outer[2] <= i_in.coord_c[SRC_COORD_BITS-1:0];
                    r_outer[3] <= i_in.coord_d[SRC_COORD_BITS-1:0];
                end
                OP_LOAD_CORE: begin
                    r_core[0] <= i_in.coord_a[SRC_COORD_BITS-1:0];
                    r_core[1] <= i_in.coord_b[SRC_COORD_BITS-1:0];
                    r_core[2] <= i_in.coord_c[SRC_COORD_BITS-1:0];
                    r_core[3] <= i_in.coord_d[SRC_COORD_BITS-1:0];
                end
                OP_LOAD_PIVOT: begin
                    r_pivot[0] <= i_in.coord_a[SRC_COORD_BITS-1:0];
                    r_pivot[1] <= i_in.coord_b[SRC_COORD_BITS-1:0];
                    r_has_core <= i_in.nine_slice;
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake chain: a stage advances when the one after it can take its contents
    assign s3_ready   = !r_s3_v || lay_ready;
    assign s2_ready   = !r_s2_v || s3_ready;
    assign s1_ready   = !r_s1_v || s2_ready;
    assign s0_ready   = !r_s0_v || s1_ready;
    assign o_in_ready = s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s0_ready) r_s0_v <= in_acc && is_draw;
            if (s1_ready) r_s1_v <= r_s0_v;
            if (s2_ready) r_s2_v <= r_s1_v;
            if (s3_ready) r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && in_acc && is_draw) r_s0 <= n_s0;
        if (s1_ready && r_s0_v) r_s1 <= n_s1;
        if (s2_ready && r_s1_v) r_s2 <= n_s2;
        if (s3_ready && r_s2_v) r_s3 <= n_s3;
    end

    // Stage 0: snapshot the frame, clamp the core into the atlas
    always_comb begin
        n_s0.x        = i_in.coord_a;
        n_s0.y        = i_in.coord_b;
        n_s0.w        = i_in.coord_c;
        n_s0.h        = i_in.coord_d;
        n_s0.has_core = r_has_core;
        n_s0.ox0      = r_outer[0];
        n_s0.oy0      = r_outer[1];
        n_s0.ox1      = r_outer[2];
        n_s0.oy1      = r_outer[3];
        n_s0.cx0      = sat_src({1'b0, r_outer[0]} + {1'b0, r_core[0]});
        n_s0.cy0      = sat_src({1'b0, r_outer[1]} + {1'b0, r_core[1]});
        n_s0.cx1      = sat_src({1'b0, r_outer[0]} + {1'b0, r_core[2]});
        n_s0.cy1      = sat_src({1'b0, r_outer[1]} + {1'b0, r_core[3]});
        n_s0.px       = r_pivot[0];
        n_s0.py       = r_pivot[1];
        n_s0.s        = (r_scale == '0) ? SCALE_ONE : r_scale;
    end

    // Stage 1: scale pivot, frame size and corner widths
    always_comb begin
        n_s1.x        = r_s0.x;
        n_s1.y        = r_s0.y;
        n_s1.w        = r_s0.w;
        n_s1.h        = r_s0.h;
        n_s1.has_core = r_s0.has_core;
        n_s1.ox0      = r_s0.ox0;
        n_s1.oy0      = r_s0.oy0;
        n_s1.ox1      = r_s0.ox1;
        n_s1.oy1      = r_s0.oy1;
        n_s1.cx0      = r_s0.cx0;
        n_s1.cy0      = r_s0.cy0;
        n_s1.cx1      = r_s0.cx1;
        n_s1.cy1      = r_s0.cy1;
        n_s1.spx      = scale_px($signed({1'b0, r_s0.px}), r_s0.s);
        n_s1.spy      = scale_px($signed({1'b0, r_s0.py}), r_s0.s);
        n_s1.ow       = scale_px(src_diff(r_s0.ox1, r_s0.ox0), r_s0.s);
        n_s1.oh       = scale_px(src_diff(r_s0.oy1, r_s0.oy0), r_s0.s);
        n_s1.sdx0     = scale_px(src_diff(r_s0.cx0, r_s0.ox0), r_s0.s);
        n_s1.sdy0     = scale_px(src_diff(r_s0.cy0, r_s0.oy0), r_s0.s);
        n_s1.sdx1     = scale_px(src_diff(r_s0.ox1, r_s0.cx1), r_s0.s);
        n_s1.sdy1     = scale_px(src_diff(r_s0.oy1, r_s0.cy1), r_s0.s);
    end

    // Stage 2: shift the destination by the scaled pivot
    always_comb begin
        n_s2.l        = sat_dst((DST_W+1)'(r_s1.x) - (DST_W+1)'(r_s1.spx));
        n_s2.t        = sat_dst((DST_W+1)'(r_s1.y) - (DST_W+1)'(r_s1.spy));
        n_s2.w        = r_s1.w;
        n_s2.h        = r_s1.h;
        n_s2.has_core = r_s1.has_core;
        n_s2.ox0      = r_s1.ox0;
        n_s2.oy0      = r_s1.oy0;
        n_s2.ox1      = r_s1.ox1;
        n_s2.oy1      = r_s1.oy1;
        n_s2.cx0      = r_s1.cx0;
        n_s2.cy0      = r_s1.cy0;
        n_s2.cx1      = r_s1.cx1;
        n_s2.cy1      = r_s1.cy1;
        n_s2.ow       = r_s1.ow;
        n_s2.oh       = r_s1.oh;
        n_s2.sdx0     = r_s1.sdx0;
        n_s2.sdy0     = r_s1.sdy0;
        n_s2.sdx1     = r_s1.sdx1;
        n_s2.sdy1     = r_s1.sdy1;
    end

    // Stage 3: right and bottom edges, widened to the scaled frame; core top-left edges
    assign r0      = sat_dst((DST_W+1)'(r_s2.w) + (DST_W+1)'(r_s2.l));
    assign b0      = sat_dst((DST_W+1)'(r_s2.h) + (DST_W+1)'(r_s2.t));
    assign r0_diff = (DST_W+1)'(r0) - (DST_W+1)'(r_s2.l);
    assign b0_diff = (DST_W+1)'(b0) - (DST_W+1)'(r_s2.t);

    always_comb begin
        n_s3.l        = r_s2.l;
        n_s3.t        = r_s2.t;
        n_s3.r        = (r0_diff < (DST_W+1)'(r_s2.ow)) ?
                        sat_dst((DST_W+1)'(r_s2.l) + (DST_W+1)'(r_s2.ow)) : r0;
        n_s3.b        = (b0_diff < (DST_W+1)'(r_s2.oh)) ?
                        sat_dst((DST_W+1)'(r_s2.t) + (DST_W+1)'(r_s2.oh)) : b0;
        n_s3.has_core = r_s2.has_core;
        n_s3.ox0      = r_s2.ox0;
        n_s3.oy0      = r_s2.oy0;
        n_s3.ox1      = r_s2.ox1;
        n_s3.oy1      = r_s2.oy1;
        n_s3.cx0      = r_s2.cx0;
        n_s3.cy0      = r_s2.cy0;
        n_s3.cx1      = r_s2.cx1;
        n_s3.cy1      = r_s2.cy1;
        n_s3.cl       = sat_dst((DST_W+1)'(r_s2.l) + (DST_W+1)'(r_s2.sdx0));
        n_s3.ct       = sat_dst((DST_W+1)'(r_s2.t) + (DST_W+1)'(r_s2.sdy0));
        n_s3.sdx1     = r_s2.sdx1;
        n_s3.sdy1     = r_s2.sdy1;
    end

    // Core bottom-right edges, straight into the sequencer's layout register
    always_comb begin
        lay.has_core = r_s3.has_core;
        lay.ox0      = r_s3.ox0;
        lay.oy0      = r_s3.oy0;
        lay.ox1      = r_s3.ox1;
        lay.oy1      = r_s3.oy1;
        lay.cx0      = r_s3.cx0;
        lay.cy0      = r_s3.cy0;
        lay.cx1      = r_s3.cx1;
        lay.cy1      = r_s3.cy1;
        lay.dl       = r_s3.l;
        lay.dt       = r_s3.t;
        lay.dr       = r_s3.r;
        lay.db       = r_s3.b;
        lay.cl       = r_s3.cl;
        lay.ct       = r_s3.ct;
        lay.cr       = sat_dst((DST_W+1)'(r_s3.r) - (DST_W+1)'(r_s3.sdx1));
        lay.cb       = sat_dst((DST_W+1)'(r_s3.b) - (DST_W+1)'(r_s3.sdy1));
    end

    nssl_slicer u_slicer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lay       (lay),
        .i_lay_valid (r_s3_v),
        .o_lay_ready (lay_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    // A nine-slice draw keeps emitting until its last pair
    a_slice_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_slice |=> o_out_valid)
        else $error("result stream broke off before the last slice");

    a_slice_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_slice
        |=> o_out.slice_index == $past(o_out.slice_index) + 4'd1)
        else $error("slice index did not advance by one");

    a_right_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.slice_index == SL_RIGHT |-> o_out.last_slice)
        else $error("right slice not flagged as last");

    a_new_draw_at_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.last_slice
        |=> !o_out_valid || o_out.slice_index == SL_CENTRE)
        else $error("draw did not start at the centre slice");

endmodule

// ----- tb/sv/nine_slice_sprite_layout_test.sv -----
// Testbench of the nine-slice sprite layout block: directed and random frames and draws, checked pair by pair.
`timescale 1ns / 1ps

module nine_slice_sprite_layout_test;
    import nssl_pkg::*;

    localparam int CLK_PERIOD_NS    = 4;
    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_CYCLES    = 20;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int TIMEOUT_CYCLES   = 250_000;

    localparam logic [CFG_ADDR_W-1:0] SCALE_ADDR    = {REG_SCALE_FACTOR, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

    // Expands each accepted request into the rectangle pairs it must produce
    class nine_slice_plan;
        t_scale     scale;
        t_src       outer_edges[4];
        t_src       core_edges[4];
        t_src       pivot_xy[2];
        bit         core_on;
        t_out_item  pending_pairs[$];
        int         mismatches;

        function new();
            scale = SCALE_ONE;
            foreach (outer_edges[i]) outer_edges[i] = '0;
            foreach (core_edges[i]) core_edges[i] = '0;
            pivot_xy[0] = '0;
            pivot_xy[1] = '0;
            core_on = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_pairs.size();
        endfunction

        function longint clamp_q12(longint v);
            if (v > longint'(DST_MAX)) return longint'(DST_MAX);
            if (v < longint'(DST_MIN)) return longint'(DST_MIN);
            return v;
        endfunction

        function longint clip_atlas(longint v);
            if (v < 0) return 0;
            if (v > longint'(SRC_MAX)) return longint'(SRC_MAX);
            return v;
        endfunction

        // Pixels times Q4.8 scale into Q12.4, truncated toward zero
        function longint to_q12(longint px, longint sf);
            longint prod;
            prod = px * sf;
            if (prod < 0) return clamp_q12(-((-prod) >> SCALE_SHIFT));
            return clamp_q12(prod >> SCALE_SHIFT);
        endfunction

        function void push_pair(t_slice idx, longint sl, longint st, longint sr, longint sb,
                                longint dl, longint dt, longint dr, longint db, bit last);
            t_out_item p;
            p.slice_index = idx;
            p.src_left    = t_src'(sl);
            p.src_top     = t_src'(st);
            p.src_right   = t_src'(sr);
            p.src_bottom  = t_src'(sb);
            p.dst_left    = t_dst'(dl);
            p.dst_top     = t_dst'(dt);
            p.dst_right   = t_dst'(dr);
            p.dst_bottom  = t_dst'(db);
            p.last_slice  = last;
            pending_pairs.push_back(p);
        endfunction

        function void accept_request(t_in_item req);
            longint sf, l, t, r, b, ow, oh;
            longint ox0, oy0, ox1, oy1, cx0, cy0, cx1, cy1, cl, ct, cr, cb;
            case (req.operation)
                OP_LOAD_OUTER: begin
                    outer_edges[0] = t_src'(req.coord_a);
                    outer_edges[1] = t_src'(req.coord_b);
                    outer_edges[2] = t_src'(req.coord_c);
                    outer_edges[3] = t_src'(req.coord_d);
                end
                OP_LOAD_CORE: begin
                    core_edges[0] = t_src'(req.coord_a);
                    core_edges[1] = t_src'(req.coord_b);
                    core_edges[2] = t_src'(req.coord_c);
                    core_edges[3] = t_src'(req.coord_d);
                end
                OP_LOAD_PIVOT: begin
                    pivot_xy[0] = t_src'(req.coord_a);
                    pivot_xy[1] = t_src'(req.coord_b);
                    core_on     = req.nine_slice;
                end
                default: begin
                    // a zero scale acts as one
                    sf  = (scale == '0) ? longint'(SCALE_ONE) : longint'(scale);
                    ox0 = longint'(outer_edges[0]);
                    oy0 = longint'(outer_edges[1]);
                    ox1 = longint'(outer_edges[2]);
                    oy1 = longint'(outer_edges[3]);
                    l  = clamp_q12(longint'(req.coord_a) - to_q12(longint'(pivot_xy[0]), sf));
                    t  = clamp_q12(longint'(req.coord_b) - to_q12(longint'(pivot_xy[1]), sf));
                    r  = clamp_q12(longint'(req.coord_c) + l);
                    b  = clamp_q12(longint'(req.coord_d) + t);
                    ow = to_q12(ox1 - ox0, sf);
                    oh = to_q12(oy1 - oy0, sf);
                    // widen to at least the scaled frame
                    if (r - l < ow) r = clamp_q12(l + ow);
                    if (b - t < oh) b = clamp_q12(t + oh);
                    if (!core_on) begin
                        push_pair(SL_CENTRE, ox0, oy0, ox1, oy1, l, t, r, b, 1'b1);
                    end else begin
                        cx0 = clip_atlas(ox0 + longint'(core_edges[0]));
                        cy0 = clip_atlas(oy0 + longint'(core_edges[1]));
                        cx1 = clip_atlas(ox0 + longint'(core_edges[2]));
                        cy1 = clip_atlas(oy0 + longint'(core_edges[3]));
                        cl = clamp_q12(l + to_q12(cx0 - ox0, sf));
                        ct = clamp_q12(t + to_q12(cy0 - oy0, sf));
                        cr = clamp_q12(r - to_q12(ox1 - cx1, sf));
                        cb = clamp_q12(b - to_q12(oy1 - cy1, sf));
                        push_pair(SL_CENTRE, cx0, cy0, cx1, cy1, cl, ct, cr, cb, 1'b0);
                        push_pair(SL_TL,     ox0, oy0, cx0, cy0, l,  t,  cl, ct, 1'b0);
                        push_pair(SL_TR,     cx1, oy0, ox1, cy0, cr, t,  r,  ct, 1'b0);
                        push_pair(SL_BL,     ox0, cy1, cx0, oy1, l,  cb, cl, b,  1'b0);
                        push_pair(SL_BR,     cx1, cy1, ox1, oy1, cr, cb, r,  b,  1'b0);
                        push_pair(SL_TOP,    cx0, oy0, cx1, cy0, cl, t,  cr, ct, 1'b0);
                        push_pair(SL_BOTTOM, cx0, cy1, cx1, oy1, cl, cb, cr, b,  1'b0);
                        push_pair(SL_LEFT,   ox0, cy0, cx0, cy1, l,  ct, cl, cb, 1'b0);
                        push_pair(SL_RIGHT,  cx1, cy0, ox1, cy1, cr, ct, r,  cb, 1'b1);
                    end
                end
            endcase
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_pair(t_out_item got);
            t_out_item want;
            if (pending_pairs.size() == 0) begin
                mismatches++;
                $display("%0t: pair expected none, got %p", $time, got);
                return;
            end
            want = pending_pairs.pop_front();
            check_field("slice_index", want.slice_index, got.slice_index);
            check_field("src_left", want.src_left, got.src_left);
            check_field("src_top", want.src_top, got.src_top);
            check_field("src_right", want.src_right, got.src_right);
            check_field("src_bottom", want.src_bottom, got.src_bottom);
            check_field("dst_left", longint'(want.dst_left), longint'(got.dst_left));
            check_field("dst_top", longint'(want.dst_top), longint'(got.dst_top));
            check_field("dst_right", longint'(want.dst_right), longint'(got.dst_right));
            check_field("dst_bottom", longint'(want.dst_bottom), longint'(got.dst_bottom));
            check_field("last_slice", want.last_slice, got.last_slice);
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_req   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_pair;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    nine_slice_plan plan;

    nine_slice_sprite_layout dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_pair),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #(CLK_PERIOD_NS / 2.0) clk = ~clk;
    end

    function automatic t_in_item make_request(t_op op, int a, int b, int c, int d, bit nine);
        t_in_item r;
        r.operation  = op;
        r.coord_a    = t_dst'(a);
        r.coord_b    = t_dst'(b);
        r.coord_c    = t_dst'(c);
        r.coord_d    = t_dst'(d);
        r.nine_slice = nine;
        return r;
    endfunction

    function automatic int rand_word();
        return int'($urandom_range(0, 65535));
    endfunction

    // Mostly within [lo, hi], now and then any 16-bit pattern
    function automatic int rand_coord(int lo, int hi);
        if ($urandom_range(7) == 0) return rand_word();
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Hold valid across back-to-back requests; drop it only for an idle gap
    task automatic send_request(input t_in_item req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        plan.accept_request(req);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[CFG_ADDR_W-1:2] == REG_SCALE_FACTOR) plan.scale = t_scale'(value);
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (plan.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame, now and then with random outer bounds, followed by a handful of draws
    task automatic send_sprite(output int count);
        int x0, y0, w, h, cl, ct, draws;
        x0 = $urandom_range(0, 3500);
        y0 = $urandom_range(0, 3500);
        w  = $urandom_range(0, 4095 - x0);
        h  = $urandom_range(0, 4095 - y0);
        if ($urandom_range(7) == 0) begin
            send_request(make_request(OP_LOAD_OUTER, rand_word(), rand_word(), rand_word(),
                                      rand_word(), $urandom_range(1)));
        end else begin
            send_request(make_request(OP_LOAD_OUTER, x0, y0, x0 + w, y0 + h,
                                      $urandom_range(1)));
        end
        cl = $urandom_range(0, w);
        ct = $urandom_range(0, h);
        send_request(make_request(OP_LOAD_CORE, cl, ct, $urandom_range(cl, w),
                                  $urandom_range(ct, h), $urandom_range(1)));
        send_request(make_request(OP_LOAD_PIVOT, $urandom_range(0, w), $urandom_range(0, h),
                                  rand_word(), rand_word(), $urandom_range(3) != 0));
        draws = $urandom_range(1, 4);
        repeat (draws) begin
            send_request(make_request(OP_DRAW, rand_coord(-8000, 8000), rand_coord(-8000, 8000),
                                      rand_coord(0, 4000), rand_coord(0, 4000),
                                      $urandom_range(1)));
        end
        count = 3 + draws;
    endtask

    task automatic send_directed();
        t_in_item reqs[$];
        reqs.push_back(make_request(OP_DRAW, 0, 0, 0, 0, 1'b0));
        // wrapped loads: outer is inverted vertically
        reqs.push_back(make_request(OP_LOAD_OUTER, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 1'b0));
        reqs.push_back(make_request(OP_LOAD_PIVOT, 16'hFFFF, 0, 16'h7FFF, 16'h8000, 1'b0));
        reqs.push_back(make_request(OP_DRAW, 32767, -32768, 32767, -32768, 1'b1));
        reqs.push_back(make_request(OP_DRAW, -32768, 32767, -32768, 32767, 1'b0));
        reqs.push_back(make_request(OP_LOAD_OUTER, 100, 200, 300, 400, 1'b1));
        reqs.push_back(make_request(OP_LOAD_CORE, 10, 20, 150, 180, 1'b1));
        reqs.push_back(make_request(OP_LOAD_PIVOT, 50, 60, 16'h5A5A, 16'hA5A5, 1'b1));
        reqs.push_back(make_request(OP_DRAW, 1000, 2000, 16, 16, 1'b0));
        reqs.push_back(make_request(OP_DRAW, -500, -600, 20000, 20000, 1'b1));
        // core reaching past the atlas edge
        reqs.push_back(make_request(OP_LOAD_CORE, 4000, 4000, 4095, 4095, 1'b0));
        reqs.push_back(make_request(OP_LOAD_OUTER, 4000, 4000, 4095, 4095, 1'b0));
        reqs.push_back(make_request(OP_DRAW, 0, 0, 0, 0, 1'b0));
        reqs.push_back(make_request(OP_LOAD_CORE, 200, 200, 10, 10, 1'b0));
        reqs.push_back(make_request(OP_LOAD_OUTER, 0, 0, 4095, 4095, 1'b0));
        reqs.push_back(make_request(OP_DRAW, 32767, 32767, 32767, 32767, 1'b0));
        reqs.push_back(make_request(OP_DRAW, -32768, -32768, -32768, -32768, 1'b1));
        reqs.push_back(make_request(OP_LOAD_PIVOT, 4095, 4095, 0, 0, 1'b1));
        reqs.push_back(make_request(OP_DRAW, -32768, -32768, 32767, 32767, 1'b0));
        reqs.push_back(make_request(OP_LOAD_PIVOT, 0, 0, -1, -1, 1'b0));
        reqs.push_back(make_request(OP_DRAW, 100, 100, -200, -200, 1'b1));
        foreach (reqs[i]) send_request(reqs[i]);
    endtask

    // Result side: take pairs at the edge, then pick the next ready value
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) plan.check_pair(out_pair);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int phase, sent, count;
        logic [31:0] scale_setting;
        plan = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            case (phase)
                0: scale_setting = 32'd256;
                1: scale_setting = 32'd4095;
                2: scale_setting = 32'd1;
                3: scale_setting = 32'd0;
                default: scale_setting = $urandom_range(1, 4095);
            endcase
            drain_results();
            write_reg(SCALE_ADDR, scale_setting);
            if (phase == 0) begin
                // nothing lives beyond the scale register
                write_reg(UNMAPPED_ADDR, 32'h0000_0123);
                send_directed();
            end
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    send_sprite(count);
                    sent += count;
                end else begin
                    send_request(make_request(t_op'($urandom_range(3)), rand_word(), rand_word(),
                                              rand_word(), rand_word(), $urandom_range(1)));
                    sent++;
                end
            end
            in_valid <= 1'b0;
        end
        drain_results();
        if (plan.mismatches == 0 && plan.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/nssl_pkg.sv
hdl/nssl_slicer.sv
hdl/nine_slice_sprite_layout.sv
tb/sv/nine_slice_sprite_layout_test.sv
